// File: hw/rtl/min_cost_assignment_solver_defines.svh
// assertion macros used by the checker file
`ifndef MIN_COST_ASSIGNMENT_SOLVER_DEFINES_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_DEFINES_SVH

// a condition that must imply a result in the next cycle
`define MCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

// a condition that must hold in the same cycle
`define MCA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("check failed");

`endif

// File: hw/rtl/mca_pkg.sv
// ----------------------------------------------------------------------------
// mca_pkg
// types and constants of the minimum-cost assignment solver
// ----------------------------------------------------------------------------
package mca_pkg;
	localparam int MCA_MAX_SIZE  = 16;
	localparam int MCA_COST_BITS = 16;
	localparam int POT_BITS      = 32;
	localparam logic [POT_BITS-1:0] SLACK_TOP = {1'b0, {(POT_BITS-1){1'b1}}};

	localparam logic [0:0] REG_SIZE_IN_USE = 1'b0;

	typedef struct packed {
		logic [3:0]  row_index;
		logic [3:0]  col_index;
		logic [15:0] cost_value;
		logic        last_entry;
	} mca_in_t;

	typedef struct packed {
		logic [3:0] worker;
		logic [3:0] job;
		logic       final_pair;
	} mca_out_t;
endpackage

// File: hw/rtl/min_cost_assignment_solver.sv
// ----------------------------------------------------------------------------
// min_cost_assignment_solver
// minimum-cost square assignment by the potential-based hungarian method
// ----------------------------------------------------------------------------
// Cost entries are written one per item into a cost memory, one per cycle while stall is low.
// An item with last_entry set starts a solve; while it runs and until all of
// its result items are taken, stall is high.
// The solve runs one row at a time; each augmenting step scans the N columns
// with one cost memory read per cycle, and a row takes up to N steps. Then N
// result items come out in worker order, one per cycle when not stalled.
module min_cost_assignment_solver #(
	parameter int MAX_SIZE  = mca_pkg::MCA_MAX_SIZE,
	parameter int COST_BITS = mca_pkg::MCA_COST_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mca_pkg::mca_in_t      in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mca_pkg::mca_out_t     out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import mca_pkg::*;

	localparam int IW = $clog2(MAX_SIZE);
	localparam int CW = $clog2(MAX_SIZE + 1);
	localparam int AW = 2 * IW;
	localparam int NE = MAX_SIZE + 1;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_ROW   = 4'd2;
	localparam logic [3:0] ST_STEP  = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_AUG   = 4'd6;
	localparam logic [3:0] ST_EMIT  = 4'd7;
	localparam logic [3:0] ST_SCAN2 = 4'd8;

	logic [3:0] state_q;
	logic [4:0] size_q;
	logic [CW-1:0] n_q, row_q, cur_q, nxt_q, j_q, emit_q;
	logic [CW-1:0] r_q;
	logic [POT_BITS-1:0] delta_q, ur_q;

	// small state arrays, each entry read at its own place or by one index
	logic [POT_BITS-1:0] u_q [NE];
	logic [POT_BITS-1:0] v_q [NE];
	logic [POT_BITS-1:0] sl_q [NE];
	logic [CW-1:0] own_q [NE];
	logic [CW-1:0] lnk_q [NE];
	logic [NE-1:0] used_q;

	// cost memory
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [COST_BITS-1:0] mem_wdata, mem_rdata;

	assign mem_we    = (state_q == ST_LOAD) && in_valid &&
		(in_data.row_index < MAX_SIZE) && (in_data.col_index < MAX_SIZE);
	assign mem_waddr = {IW'(in_data.row_index), IW'(in_data.col_index)};
	assign mem_wdata = COST_BITS'(in_data.cost_value);
	assign mem_raddr = {IW'(r_q - 1'b1), IW'(j_q - 1'b1)};

	mca_cost_mem #(.MAX_SIZE(MAX_SIZE), .COST_BITS(COST_BITS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {27'd0, size_q} : 32'd0;
	assign in_stall = (state_q != ST_LOAD);

	// scan stage 2: column j_s1 has cost in mem_rdata
	logic [CW-1:0] j_s1;
	logic scan_v_s1;
	logic [POT_BITS-1:0] red, sl_new;
	always_comb begin
		red = POT_BITS'(mem_rdata) - ur_q - v_q[j_s1];
		sl_new = ($signed(red) < $signed(sl_q[j_s1])) ? red : sl_q[j_s1];
	end

	logic [CW-1:0] job_sel;
	always_comb begin
		job_sel = '0;
		for (int k = 1; k < NE; k++) begin
			if (k <= n_q && own_q[k] == CW'(emit_q + 1'b1)) job_sel = CW'(k - 1);
		end
	end
	assign out_valid = (state_q == ST_EMIT);
	assign out_data.worker = 4'(emit_q);
	assign out_data.job = 4'(job_sel);
	assign out_data.final_pair = (CW'(emit_q + 1'b1) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= 5'd16;
			used_q <= '0;
			scan_v_s1 <= 1'b0;
			n_q <= '0; row_q <= '0; cur_q <= '0; nxt_q <= '0; j_q <= '0;
			emit_q <= '0; r_q <= '0; j_s1 <= '0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == REG_SIZE_IN_USE)
				size_q <= pwdata[4:0];
			case (state_q)
				ST_LOAD: begin
					if (in_valid && in_data.last_entry) begin
						if (size_q == 0) n_q <= CW'(1);
						else if (size_q > MAX_SIZE) n_q <= CW'(MAX_SIZE);
						else n_q <= CW'(size_q);
						j_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					for (int k = 0; k < NE; k++) begin
						u_q[k] <= '0; v_q[k] <= '0; own_q[k] <= '0; lnk_q[k] <= '0;
					end
					row_q <= CW'(1);
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					for (int k = 0; k < NE; k++) sl_q[k] <= SLACK_TOP;
					used_q <= '0;
					own_q[0] <= row_q;
					cur_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					used_q[cur_q] <= 1'b1;
					r_q <= own_q[cur_q];
					ur_q <= u_q[own_q[cur_q]];
					delta_q <= SLACK_TOP;
					nxt_q <= '0;
					j_q <= CW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// issue read for column j_q, finish column j_s1
					if (j_q <= n_q) begin
						scan_v_s1 <= !used_q[j_q];
						j_s1 <= j_q;
						j_q <= CW'(j_q + 1'b1);
					end else begin
						scan_v_s1 <= 1'b0;
						if (!scan_v_s1) state_q <= ST_SCAN2;
					end
					if (scan_v_s1) begin
						sl_q[j_s1] <= sl_new;
						if ($signed(red) < $signed(sl_q[j_s1])) lnk_q[j_s1] <= cur_q;
						if ($signed(sl_new) < $signed(delta_q)) begin
							delta_q <= sl_new;
							nxt_q <= j_s1;
						end
					end
				end
				ST_SCAN2: begin
					if (nxt_q == 0) begin
						state_q <= ST_AUG;
					end else begin
						j_q <= '0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// one column per cycle
					if (used_q[j_q]) begin
						u_q[own_q[j_q]] <= u_q[own_q[j_q]] + delta_q;
						v_q[j_q] <= v_q[j_q] - delta_q;
					end else begin
						sl_q[j_q] <= sl_q[j_q] - delta_q;
					end
					if (j_q == n_q) begin
						cur_q <= nxt_q;
						state_q <= (own_q[nxt_q] != 0) ? ST_STEP : ST_AUG;
					end else begin
						j_q <= CW'(j_q + 1'b1);
					end
				end
				ST_AUG: begin
					if (cur_q != 0) begin
						own_q[cur_q] <= own_q[lnk_q[cur_q]];
						cur_q <= lnk_q[cur_q];
					end else if (row_q == n_q) begin
						emit_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						row_q <= CW'(row_q + 1'b1);
						state_q <= ST_ROW;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (CW'(emit_q + 1'b1) == n_q) state_q <= ST_LOAD;
						emit_q <= CW'(emit_q + 1'b1);
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// File: hw/rtl/mca_cost_mem.sv
// ----------------------------------------------------------------------------
// mca_cost_mem
// cost matrix store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mca_cost_mem #(
	parameter int MAX_SIZE  = 16,
	parameter int COST_BITS = 16,
	localparam int AW = 2 * $clog2(MAX_SIZE)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [COST_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [COST_BITS-1:0] rdata
);
	// addressed as {row, column}, so the depth follows the address width
	logic [COST_BITS-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/mca_checker.sv
// ----------------------------------------------------------------------------
// mca_checker
// port-level checks of the assignment solver
// ----------------------------------------------------------------------------
`include "min_cost_assignment_solver_defines.svh"
module mca_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input mca_pkg::mca_out_t out_data,
	input logic              pready
);
	import mca_pkg::*;

	`MCA_ASSERT_NOW(a_no_in_while_out, out_valid, in_stall)
	`MCA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`MCA_ASSERT_NEXT(a_worker_step, out_valid && !out_stall && !out_data.final_pair,
		out_valid && out_data.worker == $past(out_data.worker) + 4'd1)
	`MCA_ASSERT_NEXT(a_done_free, out_valid && !out_stall && out_data.final_pair,
		!out_valid && !in_stall)
	`MCA_ASSERT_NOW(a_ready, 1'b1, pready)
endmodule

bind min_cost_assignment_solver mca_checker u_mca_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .pready(pready)
);
